// ----- design/flc_pkg.sv -----
`default_nettype none

package flc_pkg;

	// Field and state widths
	localparam int SAMPLE_W    = 24;
	localparam int PHASE_W     = 24;
	localparam int ADDR_W      = 11;
	localparam int DELAY_DEPTH = 1 << ADDR_W;
	localparam int FRAC_W      = 16;
	localparam int DELAY_W     = 27;
	localparam int INC_W       = 24;
	localparam int GAIN_W      = 16;
	localparam int LFO_W       = 17;
	localparam int IDX_W       = 3;
	localparam int CFG_DATA_W  = 27;
	localparam int SWEEP_P_W   = DELAY_W + LFO_W;
	localparam int POS_W       = ADDR_W + FRAC_W;

	// Datapath widths: coefficients, Horner accumulator, multiplier, dry/wet sum
	localparam int CW    = SAMPLE_W + 4;
	localparam int TW    = SAMPLE_W + 6;
	localparam int MB_W  = GAIN_W + 1;
	localparam int MP_W  = TW + MB_W;
	localparam int SUM_W = SAMPLE_W + 9;

	typedef enum logic [IDX_W-1:0] {
		REG_BASE_DELAY  = 3'd0,
		REG_SWEEP_WIDTH = 3'd1,
		REG_PHASE_INC   = 3'd2,
		REG_MIX_DEPTH   = 3'd3,
		REG_FEEDBACK    = 3'd4,
		REG_INVERT_WET  = 3'd5,
		REG_LFO_SHAPE   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		SHAPE_SINE     = 2'd0,
		SHAPE_TRIANGLE = 2'd1,
		SHAPE_SAW      = 2'd2,
		SHAPE_INV_SAW  = 2'd3
	} lfo_shape_t;

	localparam logic [DELAY_W-1:0] BASE_DELAY_RST  = 27'd23592960;
	localparam logic [DELAY_W-1:0] SWEEP_WIDTH_RST = 27'd3145728;
	localparam logic [INC_W-1:0]   PHASE_INC_RST   = 24'd349;
	localparam logic [GAIN_W-1:0]  MIX_DEPTH_RST   = 16'd16384;
	localparam logic [GAIN_W-1:0]  FEEDBACK_RST    = 16'd0;

	typedef struct packed {
		logic [DELAY_W-1:0] base_delay;
		logic [DELAY_W-1:0] sweep_width;
		logic [INC_W-1:0]   phase_increment;
		logic [GAIN_W-1:0]  mix_depth;
		logic [GAIN_W-1:0]  feedback_gain;
		logic               invert_wet;
		lfo_shape_t         lfo_shape;
	} cfg_t;

	typedef struct packed {
		logic                we;
		logic [ADDR_W-1:0]   waddr;
		logic [SAMPLE_W-1:0] wdata;
		logic [ADDR_W-1:0]   raddr;
	} mem_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_POS,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_COEF,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_WMIX,
		ST_WFB
	} state_t;

	// Quarter-wave sine, round(65536*sin(k*pi/32)) for k = 0..16
	function automatic logic [LFO_W-1:0] sine_quarter(input logic [4:0] k);
		logic [LFO_W-1:0] r;
		case (k)
			5'd0:    r = 17'd0;
			5'd1:    r = 17'd6424;
			5'd2:    r = 17'd12785;
			5'd3:    r = 17'd19024;
			5'd4:    r = 17'd25080;
			5'd5:    r = 17'd30893;
			5'd6:    r = 17'd36410;
			5'd7:    r = 17'd41576;
			5'd8:    r = 17'd46341;
			5'd9:    r = 17'd50660;
			5'd10:   r = 17'd54491;
			5'd11:   r = 17'd57798;
			5'd12:   r = 17'd60547;
			5'd13:   r = 17'd62714;
			5'd14:   r = 17'd64277;
			5'd15:   r = 17'd65220;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	// Clamp a wide signed sum to the sample range
	function automatic logic signed [SAMPLE_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if ((&v[SUM_W-1:SAMPLE_W-1]) || !(|v[SUM_W-1:SAMPLE_W-1])) begin
			r = v[SAMPLE_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/flc_if.sv -----
`default_nettype none

interface flc_in_if;
	logic                        valid;
	logic                        ready;
	logic signed [flc_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface flc_out_if;
	logic                        valid;
	logic                        ready;
	logic signed [flc_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

interface flc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [flc_pkg::IDX_W-1:0]         index;
	logic [flc_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/flc_cfg_regs.sv -----
`default_nettype none

module flc_cfg_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	flc_cfg_if.sink            cfg,
	output flc_pkg::cfg_t      regs
);

	flc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.base_delay      <= flc_pkg::BASE_DELAY_RST;
			regs_q.sweep_width     <= flc_pkg::SWEEP_WIDTH_RST;
			regs_q.phase_increment <= flc_pkg::PHASE_INC_RST;
			regs_q.mix_depth       <= flc_pkg::MIX_DEPTH_RST;
			regs_q.feedback_gain   <= flc_pkg::FEEDBACK_RST;
			regs_q.invert_wet      <= 1'b0;
			regs_q.lfo_shape       <= flc_pkg::SHAPE_TRIANGLE;
		end else if (cfg.valid) begin
			case (cfg.index)
				flc_pkg::REG_BASE_DELAY:  regs_q.base_delay <= cfg.data[flc_pkg::DELAY_W-1:0];
				flc_pkg::REG_SWEEP_WIDTH: regs_q.sweep_width <= cfg.data[flc_pkg::DELAY_W-1:0];
				flc_pkg::REG_PHASE_INC:   regs_q.phase_increment <= cfg.data[flc_pkg::INC_W-1:0];
				flc_pkg::REG_MIX_DEPTH:   regs_q.mix_depth <= cfg.data[flc_pkg::GAIN_W-1:0];
				flc_pkg::REG_FEEDBACK:    regs_q.feedback_gain <= cfg.data[flc_pkg::GAIN_W-1:0];
				flc_pkg::REG_INVERT_WET:  regs_q.invert_wet <= cfg.data[0];
				flc_pkg::REG_LFO_SHAPE:   regs_q.lfo_shape <= flc_pkg::lfo_shape_t'(cfg.data[1:0]);
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/flc_lfo.sv -----
`default_nettype none

module flc_lfo (
	input  wire logic [15:0]                 phase,
	input  wire flc_pkg::lfo_shape_t         shape,
	output logic [flc_pkg::LFO_W-1:0]        lfo
);

	logic [1:0]                 quad;
	logic [14:0]                x;
	logic [4:0]                 k;
	logic [9:0]                 frac;
	logic [flc_pkg::LFO_W-1:0]  lo_val;
	logic [flc_pkg::LFO_W-1:0]  hi_val;
	logic [12:0]                diff;
	logic [22:0]                step;
	logic [flc_pkg::LFO_W-1:0]  s;
	logic [flc_pkg::LFO_W-1:0]  half;
	logic [17:0]                p2;
	logic [17:0]                tri_v;
	logic [17:0]                inv_v;

	// Sine: fold onto the quarter wave, interpolate between table points
	always_comb begin
		quad = phase[15:14];
		x    = {1'b0, phase[13:0]};
		if (quad[0]) begin
			x = 15'd16384 - x;
		end
		k      = x[14:10];
		frac   = x[9:0];
		lo_val = flc_pkg::sine_quarter(k);
		hi_val = flc_pkg::sine_quarter(k + 5'd1);
		diff   = 13'(hi_val - lo_val);
		step   = diff * frac;
		s      = k[4] ? 17'd65536 : lo_val + {4'd0, step[22:10]};
		half   = {1'b0, s[16:1]};
	end

	always_comb begin
		p2 = {1'b0, phase, 1'b0};
		if (phase < 16'd16384) begin
			tri_v = 18'd32768 + p2;
		end else if (phase < 16'd49152) begin
			tri_v = 18'd98304 - p2;
		end else begin
			tri_v = p2 - 18'd98304;
		end
		if (!phase[15]) begin
			inv_v = 18'd32768 - {2'b0, phase};
		end else begin
			inv_v = 18'd98304 - {2'b0, phase};
		end
	end

	always_comb begin
		case (shape)
			flc_pkg::SHAPE_SINE:     lfo = quad[1] ? 17'd32768 - half : 17'd32768 + half;
			flc_pkg::SHAPE_TRIANGLE: lfo = tri_v[16:0];
			flc_pkg::SHAPE_SAW:      lfo = {1'b0, ~phase[15], phase[14:0]};
			flc_pkg::SHAPE_INV_SAW:  lfo = inv_v[16:0];
			default:                 lfo = 17'd32768;
		endcase
	end

endmodule

`default_nettype wire

// ----- design/flc_mem.sv -----
`default_nettype none

module flc_mem (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire flc_pkg::mem_req_t              req,
	output logic signed [flc_pkg::SAMPLE_W-1:0] rd_data
);

	logic [flc_pkg::SAMPLE_W-1:0] mem [flc_pkg::DELAY_DEPTH];
	logic [flc_pkg::SAMPLE_W-1:0] rd_data_q;
	logic                         rd_valid_q;
	logic [flc_pkg::ADDR_W:0]     fill_q;

	// Writes go in address order from zero, so an entry holds data once
	// the fill count has passed it; below that it reads as silence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.we && (fill_q != (flc_pkg::ADDR_W+1)'(flc_pkg::DELAY_DEPTH))) begin
				fill_q <= fill_q + 1'b1;
			end
			rd_valid_q <= fill_q > {1'b0, req.raddr};
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_data_q <= mem[req.raddr];
	end

	assign rd_data = rd_valid_q ? $signed(rd_data_q) : '0;

endmodule

`default_nettype wire

// ----- design/flanger_cubic_delay.sv -----
// Flanger with a cubic-interpolated, LFO-modulated delay line.
// Channels: din carries one signed Q1.23 sample per item, dout carries the
// dry-plus-wet result, cfg writes one control register (index, data) per
// handshake and is always ready. Write cfg only while no item is in flight.
// Each accepted item yields exactly one result item.
// The result shows on dout from the output register once the item commits.
// Items do not overlap: din is ready only in the idle step, because the four
// tap reads share the single read port of the delay memory and the five
// passes of the Horner / gain products go through one shared multiplier.
// Reset: registers take their defaults, write pointer and LFO phase clear.
// The delay memory needs no clearing pass: a fill count makes entries not
// yet written read as zero, so din is ready in the first cycle after reset.
// Receiver stall: the result waits in the output register while the next
// item is accepted and processed; that item then holds in its last step,
// before touching the memory, until the output register frees up.
`default_nettype none

module flanger_cubic_delay (
	input  wire logic clk,
	input  wire logic arst_n,
	flc_in_if.sink    din,
	flc_out_if.source dout,
	flc_cfg_if.sink   cfg
);

	localparam int SW = flc_pkg::SAMPLE_W;
	localparam int AW = flc_pkg::ADDR_W;
	localparam int FW = flc_pkg::FRAC_W;
	localparam int CW = flc_pkg::CW;
	localparam int TW = flc_pkg::TW;

	flc_pkg::cfg_t     regs;
	flc_pkg::state_t   state_q;
	flc_pkg::state_t   state_d;
	flc_pkg::mem_req_t mem_req;

	logic signed [SW-1:0]             rd_data;
	logic [flc_pkg::LFO_W-1:0]        lfo_val;

	// Per-item working registers
	logic signed [SW-1:0]             x_q;
	logic [flc_pkg::LFO_W-1:0]        lfo_q;
	logic [flc_pkg::SWEEP_P_W-1:0]    sweep_q;
	logic [AW-1:0]                    tap_q;
	logic [FW-1:0]                    frac_q;
	logic signed [SW-1:0]             s0_q;
	logic signed [SW-1:0]             s1_q;
	logic signed [SW-1:0]             s2_q;
	logic signed [CW-1:0]             c0_q;
	logic signed [CW-1:0]             c1_q;
	logic signed [CW-1:0]             c2_q;
	logic signed [TW-1:0]             t_q;
	logic signed [SW-1:0]             y_q;

	// Block state
	logic [AW-1:0]                    wp_q;
	logic [flc_pkg::PHASE_W-1:0]      phase_q;
	logic                             out_valid_q;
	logic signed [SW-1:0]             out_data_q;

	logic                             accept;
	logic                             out_free;
	logic                             commit;

	logic [flc_pkg::DELAY_W:0]        delay;
	logic [flc_pkg::POS_W-1:0]        rpos;

	logic signed [CW-1:0]             e0, e1, e2, e3;
	logic signed [CW-1:0]             c0_d, c1_d, c2_d;

	logic signed [TW-1:0]             mul_a;
	logic signed [flc_pkg::MB_W-1:0]  mul_b;
	logic signed [flc_pkg::MP_W-1:0]  mul_p;
	logic signed [TW-1:0]             horner;
	logic signed [TW-1:0]             c0_t, c1_t, c2_t, s1_t;

	logic signed [flc_pkg::SUM_W-1:0] x_wide;
	logic signed [flc_pkg::SUM_W-1:0] gain_term;

	flc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	flc_lfo u_lfo (
		.phase (phase_q[flc_pkg::PHASE_W-1 -: 16]),
		.shape (regs.lfo_shape),
		.lfo   (lfo_val)
	);

	flc_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	assign accept   = din.valid && din.ready;
	assign out_free = !out_valid_q || dout.ready;

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_data_q;

	// Sequencer: one item walks through the steps, the write-back step
	// waits for a free output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		din.ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			flc_pkg::ST_IDLE: begin
				din.ready = 1'b1;
				if (din.valid) begin
					state_d = flc_pkg::ST_SWEEP;
				end
			end
			flc_pkg::ST_SWEEP: state_d = flc_pkg::ST_POS;
			flc_pkg::ST_POS:   state_d = flc_pkg::ST_RD0;
			flc_pkg::ST_RD0:   state_d = flc_pkg::ST_RD1;
			flc_pkg::ST_RD1:   state_d = flc_pkg::ST_RD2;
			flc_pkg::ST_RD2:   state_d = flc_pkg::ST_RD3;
			flc_pkg::ST_RD3:   state_d = flc_pkg::ST_COEF;
			flc_pkg::ST_COEF:  state_d = flc_pkg::ST_H1;
			flc_pkg::ST_H1:    state_d = flc_pkg::ST_H2;
			flc_pkg::ST_H2:    state_d = flc_pkg::ST_H3;
			flc_pkg::ST_H3:    state_d = flc_pkg::ST_WMIX;
			flc_pkg::ST_WMIX:  state_d = flc_pkg::ST_WFB;
			flc_pkg::ST_WFB: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = flc_pkg::ST_IDLE;
				end
			end
			default: state_d = flc_pkg::ST_IDLE;
		endcase
	end

	// Read position: write pointer minus the modulated delay, wrapped to
	// the memory length (a power of two, so the wrap is a truncation).
	assign delay = {1'b0, regs.base_delay} + sweep_q[flc_pkg::SWEEP_P_W-1:FW];
	assign rpos  = {wp_q, {FW{1'b0}}} - flc_pkg::POS_W'(delay);

	// Tap address: one neighbor per read step, i-1 through i+2
	always_comb begin
		mem_req.we    = commit;
		mem_req.waddr = wp_q;
		case (state_q)
			flc_pkg::ST_RD0: mem_req.raddr = tap_q - AW'(1);
			flc_pkg::ST_RD1: mem_req.raddr = tap_q;
			flc_pkg::ST_RD2: mem_req.raddr = tap_q + AW'(1);
			flc_pkg::ST_RD3: mem_req.raddr = tap_q + AW'(2);
			default:         mem_req.raddr = tap_q;
		endcase
		// Feedback sample written back at the write pointer on commit
		mem_req.wdata = flc_pkg::saturate(x_wide + gain_term);
	end

	// Doubled Catmull-Rom coefficients; the last tap comes straight off
	// the memory read port.
	assign e0   = CW'(s0_q);
	assign e1   = CW'(s1_q);
	assign e2   = CW'(s2_q);
	assign e3   = CW'(rd_data);
	assign c0_d = e3 - e0 + (e1 + (e1 <<< 1)) - (e2 + (e2 <<< 1));
	assign c1_d = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
	assign c2_d = e2 - e0;

	assign c0_t = TW'(c0_q);
	assign c1_t = TW'(c1_q);
	assign c2_t = TW'(c2_q);
	assign s1_t = TW'(s1_q);

	// Shared multiplier: Horner steps against the fraction, then the wet
	// value against mix depth and feedback gain.
	always_comb begin
		case (state_q)
			flc_pkg::ST_H1: begin
				mul_a = c0_t;
				mul_b = {1'b0, frac_q};
			end
			flc_pkg::ST_WMIX: begin
				mul_a = t_q >>> 1;
				mul_b = {1'b0, regs.mix_depth};
			end
			flc_pkg::ST_WFB: begin
				mul_a = t_q >>> 1;
				mul_b = flc_pkg::MB_W'($signed(regs.feedback_gain));
			end
			default: begin
				mul_a = t_q;
				mul_b = {1'b0, frac_q};
			end
		endcase
	end

	assign mul_p     = mul_a * mul_b;
	assign horner    = TW'(mul_p >>> FW);
	assign gain_term = flc_pkg::SUM_W'(mul_p >>> 15);
	assign x_wide    = flc_pkg::SUM_W'(x_q);

	always_ff @(posedge clk) begin
		case (state_q)
			flc_pkg::ST_IDLE: begin
				if (accept) begin
					x_q   <= din.sample_in;
					lfo_q <= lfo_val;
				end
			end
			flc_pkg::ST_SWEEP: sweep_q <= regs.sweep_width * lfo_q;
			flc_pkg::ST_POS: begin
				tap_q  <= rpos[flc_pkg::POS_W-1:FW];
				frac_q <= rpos[FW-1:0];
			end
			flc_pkg::ST_RD1:  s0_q <= rd_data;
			flc_pkg::ST_RD2:  s1_q <= rd_data;
			flc_pkg::ST_RD3:  s2_q <= rd_data;
			flc_pkg::ST_COEF: begin
				c0_q <= c0_d;
				c1_q <= c1_d;
				c2_q <= c2_d;
			end
			flc_pkg::ST_H1: t_q <= horner + c1_t;
			flc_pkg::ST_H2: t_q <= horner + c2_t;
			flc_pkg::ST_H3: t_q <= horner + (s1_t <<< 1);
			flc_pkg::ST_WMIX: begin
				y_q <= flc_pkg::saturate(regs.invert_wet ? x_wide - gain_term
				                                         : x_wide + gain_term);
			end
			default: begin
				// hold
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				wp_q        <= wp_q + AW'(1);
				phase_q     <= phase_q + regs.phase_increment;
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= y_q;
		end
	end

endmodule

`default_nettype wire
